[src/stup_pkg.sv]
// shared types, codes and character helpers for the string to unsigned parser
package stup_pkg;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // radix after reset and radix limits
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_AUTO  = 6'd0;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_OCT   = 6'd8;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] RADIX_HEX   = 6'd16;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // digit value of a non-digit character, above every legal base
  localparam logic [5:0] DIGIT_NONE = 6'd63;
  localparam logic [5:0] ALPHA_BASE = 6'd10;

  // parse phase, one-hot
  typedef enum logic [6:0] {
    PH_BLANK  = 7'b0000001,
    PH_BODY   = 7'b0000010,
    PH_ZERO   = 7'b0000100,
    PH_HEXPFX = 7'b0001000,
    PH_DIGITS = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_DRAIN  = 7'b1000000
  } phase_t;

  // base update selection
  typedef enum logic [1:0] {
    BS_KEEP = 2'd0,
    BS_DEC  = 2'd1,
    BS_OCT  = 2'd2,
    BS_HEX  = 2'd3
  } base_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      latch_base;
    logic      step;
    logic      set_sign;
    logic      mark_zero;
    logic      digit;
    base_sel_t base_sel;
    logic      emit;
    logic      clear;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_nul;
    logic is_blank;
    logic is_sign;
    logic is_zero;
    logic is_x;
    logic dig_ok;
    logic base_ok;
    logic auto_or_hex;
    logic pos_zero;
  } sts_t;

  // digit value of a character, DIGIT_NONE when it is no digit
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
      return v[5:0];
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      v = c - CH_LA;
      return v[5:0] + ALPHA_BASE;
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA;
      return v[5:0] + ALPHA_BASE;
    end
    return DIGIT_NONE;
  endfunction

  // legal base: auto or 2..36
  function automatic logic base_ok(input logic [5:0] b);
    return (b == RADIX_AUTO) || (b >= RADIX_MIN && b <= RADIX_MAX);
  endfunction

endpackage

[src/stup_in_if.sv]
// character input channel
interface stup_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

[src/stup_out_if.sv]
// result output channel
interface stup_out_if #(
  parameter int VALUE_BITS  = 64,
  parameter int OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  value;
  logic [OFFSET_BITS-1:0] end_offset;
  logic [1:0]             status;

  modport source (output valid, output value, output end_offset, output status, input ready);
  modport sink   (input valid, input value, input end_offset, input status, output ready);
endinterface

[src/stup_ctrl.sv]
// parse controller: phase state machine and handshake control
module stup_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  stup_pkg::sts_t sts,
  output stup_pkg::cmd_t cmd
);
  import stup_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   body_start;

  // input is taken whenever the result slot is free or being emptied
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // phase decode and datapath commands
  always_comb begin
    cmd        = '0;
    cmd.base_sel = BS_KEEP;
    phase_nxt  = phase_r;
    body_start = 1'b0;
    if (accept) begin
      if (phase_r == PH_DRAIN) begin
        if (in_last) begin
          cmd.clear = 1'b1;
          phase_nxt = PH_BLANK;
        end
      end else begin
        cmd.latch_base = (phase_r == PH_BLANK) && sts.pos_zero;
        if (sts.is_nul) begin
          cmd.emit  = 1'b1;
          cmd.clear = 1'b1;
          phase_nxt = in_last ? PH_BLANK : PH_DRAIN;
        end else begin
          cmd.step = 1'b1;
          unique case (phase_r) inside
            PH_BLANK: begin
              if (sts.is_blank) begin
                phase_nxt = PH_BLANK;
              end else if (sts.is_sign) begin
                cmd.set_sign = 1'b1;
                phase_nxt    = PH_BODY;
              end else begin
                body_start = 1'b1;
              end
            end
            PH_BODY: begin
              body_start = 1'b1;
            end
            PH_ZERO: begin
              if (sts.is_x) begin
                cmd.base_sel = BS_HEX;
                phase_nxt    = PH_HEXPFX;
              end else begin
                cmd.base_sel = BS_OCT;
                cmd.digit    = 1'b1;
                phase_nxt    = sts.dig_ok ? PH_DIGITS : PH_DONE;
              end
            end
            PH_HEXPFX, PH_DIGITS: begin
              cmd.digit = 1'b1;
              phase_nxt = sts.dig_ok ? PH_DIGITS : PH_DONE;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
          // first character of the number body
          if (body_start) begin
            if (!sts.base_ok) begin
              phase_nxt = PH_DONE;
            end else if (sts.is_zero && sts.auto_or_hex) begin
              cmd.mark_zero = 1'b1;
              phase_nxt     = PH_ZERO;
            end else begin
              cmd.base_sel = BS_DEC;
              cmd.digit    = 1'b1;
              phase_nxt    = sts.dig_ok ? PH_DIGITS : PH_DONE;
            end
          end
          // string end
          if (in_last) begin
            cmd.emit  = 1'b1;
            cmd.clear = 1'b1;
            phase_nxt = PH_BLANK;
          end
        end
      end
    end
  end

  // result slot occupancy
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BLANK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/stup_dp.sv]
// parse datapath: radix register, accumulator, counters and result register
module stup_dp #(
  parameter int VALUE_BITS  = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [5:0]             cfg_wdata,
  input  logic [7:0]             char_code,
  input  stup_pkg::cmd_t         cmd,
  output stup_pkg::sts_t         sts,
  output logic [VALUE_BITS-1:0]  res_value,
  output logic [OFFSET_BITS-1:0] res_end_offset,
  output logic [1:0]             res_status
);
  import stup_pkg::*;

  localparam int PW = VALUE_BITS + 6;
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;

  logic [5:0]             radix_r;
  logic [5:0]             base_r, base_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] end_r, end_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   seen_r, seen_nxt;

  logic [VALUE_BITS-1:0]  o_acc_r;
  logic [OFFSET_BITS-1:0] o_end_r;
  logic                   o_neg_r;
  logic                   o_ovf_r;
  logic                   o_bad_r;

  logic [5:0]             base_eff;
  logic [5:0]             digit;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   take;
  logic [PW-1:0]          prod;
  logic                   too_big;

  // base in force for this item: the radix on the first item of a string
  assign base_eff = cmd.latch_base ? radix_r : base_r;
  assign digit    = char_value(char_code);
  assign pos_inc  = (&pos_r) ? pos_r : pos_r + 1'b1;

  // base update
  always_comb begin
    case (cmd.base_sel)
      BS_DEC:  base_nxt = (base_eff == RADIX_AUTO) ? RADIX_DEC : base_eff;
      BS_OCT:  base_nxt = (base_eff == RADIX_AUTO) ? RADIX_OCT : base_eff;
      BS_HEX:  base_nxt = RADIX_HEX;
      default: base_nxt = base_eff;
    endcase
  end

  // character classes for the controller
  always_comb begin
    sts.is_nul      = (char_code == CH_NUL);
    sts.is_blank    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    sts.is_sign     = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    sts.is_zero     = (char_code == CH_ZERO);
    sts.is_x        = (char_code == CH_LX) || (char_code == CH_UX);
    sts.dig_ok      = (digit < base_nxt);
    sts.base_ok     = base_ok(base_eff);
    sts.auto_or_hex = (base_eff == RADIX_AUTO) || (base_eff == RADIX_HEX);
    sts.pos_zero    = (pos_r == '0);
  end

  // digit step: multiply-add with overflow from the bits above the value width
  assign take    = cmd.digit && sts.dig_ok;
  assign prod    = PW'(acc_r) * PW'(base_nxt) + PW'(digit);
  assign too_big = |prod[PW-1:VALUE_BITS];

  // next string state
  always_comb begin
    neg_nxt  = cmd.set_sign ? (char_code == CH_MINUS) : neg_r;
    seen_nxt = seen_r || cmd.mark_zero || take;
    end_nxt  = (cmd.mark_zero || take) ? pos_inc : end_r;
    pos_nxt  = cmd.step ? pos_inc : pos_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    if (take && !ovf_r) begin
      if (too_big) begin
        acc_nxt = VALUE_MASK;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = prod[VALUE_BITS-1:0];
      end
    end
  end

  // radix register and string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      base_r  <= '0;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      pos_r   <= '0;
      end_r   <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        base_r <= '0;
        neg_r  <= 1'b0;
        acc_r  <= '0;
        pos_r  <= '0;
        end_r  <= '0;
        ovf_r  <= 1'b0;
        seen_r <= 1'b0;
      end else begin
        base_r <= base_nxt;
        neg_r  <= neg_nxt;
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
        end_r  <= end_nxt;
        ovf_r  <= ovf_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // result register, loaded when a string ends
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_acc_r <= acc_nxt;
      o_end_r <= end_nxt;
      o_neg_r <= neg_nxt;
      o_ovf_r <= ovf_nxt;
      o_bad_r <= !base_ok(base_nxt) || !seen_nxt;
    end
  end

  // result formatting
  always_comb begin
    if (o_bad_r) begin
      res_value      = '0;
      res_end_offset = '0;
      res_status     = ST_INVALID;
    end else if (o_ovf_r) begin
      res_value      = VALUE_MASK;
      res_end_offset = o_end_r;
      res_status     = ST_RANGE;
    end else begin
      res_value      = o_neg_r ? (~o_acc_r + 1'b1) : o_acc_r;
      res_end_offset = o_end_r;
      res_status     = ST_OK;
    end
  end

endmodule

[src/string_to_unsigned_parser_core.sv]
// Streaming strtoul-style parser. One character is taken per clock cycle; a string
// ends with the item that has is_last set, or early at a code 0 (items after it up
// to is_last are swallowed). The result appears on out_ch in the cycle after the
// item that ends the string and is held in a one-deep result register; input stalls
// only while that register is full and out_ch.ready is low. The per-character time
// is set by the digit step, a VALUE_BITS-by-6 multiply-add with overflow detection
// computed combinationally. The radix register (reset 10, 0 = auto-detect) is sampled
// on the first character of each string. No clearing pass follows reset.
module string_to_unsigned_parser_core #(
  parameter int VALUE_BITS  = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stup_in_if.sink    in_ch,
  stup_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);
  import stup_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  stup_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.is_last),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  stup_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .char_code      (in_ch.char_code),
    .cmd            (cmd),
    .sts            (sts),
    .res_value      (out_ch.value),
    .res_end_offset (out_ch.end_offset),
    .res_status     (out_ch.status)
  );

endmodule

[src/stup_checker.sv]
// port-level checker for the parser core and its bind
module stup_checker #(
  parameter int VALUE_BITS  = 64,
  parameter int OFFSET_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_BITS-1:0]  out_value,
  input logic [OFFSET_BITS-1:0] out_end_offset,
  input logic [1:0]             out_status
);
  import stup_pkg::*;

  // a result item stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // a stalled result item keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
    else $error("stalled result item changed");

  // a new result item only follows an accepted input item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result item without an input item");

  // invalid results carry zero value and zero offset
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INVALID |-> out_value == '0 && out_end_offset == '0)
    else $error("invalid result with nonzero value or offset");

  // out-of-range results saturate to all ones
  a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |-> &out_value)
    else $error("out-of-range result not saturated");

endmodule

bind string_to_unsigned_parser_core stup_checker #(
  .VALUE_BITS  (VALUE_BITS),
  .OFFSET_BITS (OFFSET_BITS)
) u_stup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_end_offset (out_ch.end_offset),
  .out_status     (out_ch.status)
);

[test/stup_checker.sv]
// result checker for the string to unsigned parser: follows both channels and compares
`timescale 1ns / 100ps
module stup_scoreboard (
  input  logic       clk,
  input  logic       rst_n,
  stup_in_if         in_ch,
  stup_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  import stup_pkg::*;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [15:0] OFFSET_TOP = '1;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
    logic [1:0]  status;
  } number_t;

  // numbers still owed by the parser, oldest first
  number_t awaited_numbers[$];
  int      errors = 0;

  // shadow of the radix register and of the parse state
  logic [5:0]  radix_reg;
  phase_t      ph;
  bit          neg;
  logic [63:0] acc;
  logic [5:0]  base;
  logic [15:0] pos;
  logic [15:0] end_pos;
  bit          ovf;
  bit          seen;

  function automatic void clear_string();
    ph = PH_BLANK;
    neg = 0;
    acc = '0;
    base = '0;
    pos = '0;
    end_pos = '0;
    ovf = 0;
    seen = 0;
  endfunction

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] off;
    off = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      off = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      off = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      off = c - CH_UA + 8'd10;
    end else begin
      off = {2'b00, DIGIT_NONE};
    end
    return off[5:0];
  endfunction

  function automatic bit legal_base(input logic [5:0] b);
    return b == RADIX_AUTO || (b >= RADIX_MIN && b <= RADIX_MAX);
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] p);
    return (p == OFFSET_TOP) ? p : p + 16'd1;
  endfunction

  // one digit into the accumulator, saturating on overflow
  function automatic void take_digit(input logic [7:0] c);
    logic [5:0] d;
    d = digit_of(c);
    if (d >= base) begin
      ph = PH_DONE;
      return;
    end
    seen = 1;
    end_pos = bump(pos);
    if (ovf) return;
    if (acc > (ALL_ONES - 64'(d)) / 64'(base)) begin
      ovf = 1;
      acc = ALL_ONES;
    end else begin
      acc = acc * 64'(base) + 64'(d);
    end
  endfunction

  // first character after blanks and sign
  function automatic void start_body(input logic [7:0] c);
    if (!legal_base(base)) begin
      ph = PH_DONE;
      return;
    end
    if (c == CH_ZERO && (base == RADIX_AUTO || base == RADIX_HEX)) begin
      seen = 1;
      end_pos = bump(pos);
      ph = PH_ZERO;
      return;
    end
    if (base == RADIX_AUTO) base = RADIX_DEC;
    ph = PH_DIGITS;
    take_digit(c);
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (ph)
      PH_BLANK: begin
        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            ph = PH_BODY;
          end else begin
            start_body(c);
          end
        end
      end
      PH_BODY: start_body(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          base = RADIX_HEX;
          ph = PH_HEXPFX;
        end else begin
          if (base == RADIX_AUTO) base = RADIX_OCT;
          ph = PH_DIGITS;
          take_digit(c);
        end
      end
      // 0x with no hex digit after it keeps only the zero
      PH_HEXPFX: begin
        if (digit_of(c) < RADIX_HEX) begin
          ph = PH_DIGITS;
          take_digit(c);
        end else begin
          ph = PH_DONE;
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  function automatic number_t verdict();
    number_t r;
    if (!legal_base(base) || !seen) begin
      r.value = '0;
      r.end_offset = '0;
      r.status = ST_INVALID;
    end else if (ovf) begin
      r.value = ALL_ONES;
      r.end_offset = end_pos;
      r.status = ST_RANGE;
    end else begin
      r.value = neg ? (64'd0 - acc) : acc;
      r.end_offset = end_pos;
      r.status = ST_OK;
    end
    return r;
  endfunction

  // one accepted character; returns the number it completes, if any
  function automatic bit parse_step(input logic [7:0] c, input logic last,
                                    output number_t res);
    res = '0;
    // rest of a string that ended early at a null
    if (ph == PH_DRAIN) begin
      if (last) clear_string();
      return 0;
    end
    if (ph == PH_BLANK && pos == 16'd0) base = radix_reg;
    if (c == CH_NUL) begin
      res = verdict();
      clear_string();
      if (!last) ph = PH_DRAIN;
      return 1;
    end
    parse_char(c);
    pos = bump(pos);
    if (last) begin
      res = verdict();
      clear_string();
      return 1;
    end
    return 0;
  endfunction

  // watch the channels and the register port
  always @(posedge clk) begin
    number_t made;
    number_t want;
    if (!rst_n) begin
      radix_reg = RADIX_RESET;
      clear_string();
      awaited_numbers.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (parse_step(in_ch.char_code, in_ch.is_last, made))
          awaited_numbers.push_back(made);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_numbers.size() == 0) begin
          $error("result with no string awaiting it: value %h end_offset %0d status %0d",
                 out_ch.value, out_ch.end_offset, out_ch.status);
          errors++;
        end else begin
          want = awaited_numbers.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_ch.value);
            errors++;
          end
          if (out_ch.end_offset !== want.end_offset) begin
            $error("end_offset: expected %0d, got %0d", want.end_offset, out_ch.end_offset);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
        end
      end
      if (cfg_we) radix_reg = cfg_wdata;
    end
    pending <= awaited_numbers.size();
    fail_count <= errors;
  end

endmodule

[test/tb.sv]
// testbench top for the string to unsigned parser: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb;
  import stup_pkg::*;

  localparam int STRING_ITEMS = 130;
  localparam int CYCLE_LIMIT  = 800000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [5:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         sent = 0;
  bit         calm_in = 0;

  // characters of the string being built
  logic [7:0] chars[$];

  stup_in_if in_ch();
  stup_out_if #(.VALUE_BITS(64), .OFFSET_BITS(16)) out_ch();

  string_to_unsigned_parser_core #(.VALUE_BITS(64), .OFFSET_BITS(16)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stup_scoreboard chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[string_to_unsigned_parser_core] ERROR");
      $finish;
    end
  end

  // result side: random stalls with calm stretches
  initial begin
    int hold;
    bit calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // one item, after a random gap
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_chars();
    if (chars.size() == 0) chars.push_back(CH_NUL);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    sent += chars.size();
    chars.delete();
  endtask

  function automatic void add_text(input string s);
    foreach (s[i]) chars.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    add_text(s);
    send_chars();
  endtask

  // wait until every awaited number has come out, plus the output latency
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radix(input logic [5:0] r);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
  endfunction

  // digits of a number in base b, from empty through past all ones
  function automatic void add_number(input logic [5:0] b);
    logic [63:0] v;
    logic [7:0]  rev[$];
    int          pick;
    pick = $urandom_range(0, 7);
    v = '0;
    case (pick)
      0: return;
      1, 2: v = '1;
      3: v = 64'($urandom_range(0, 999));
      4: begin
        repeat ($urandom_range(1, 70)) chars.push_back(digit_char($urandom_range(0, b - 1)));
        return;
      end
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    do begin
      rev.push_front(digit_char(int'(v % 64'(b))));
      v = v / 64'(b);
    end while (v != 0);
    foreach (rev[i]) chars.push_back(rev[i]);
    // one digit beyond all ones always overflows
    if (pick == 2) chars.push_back(digit_char($urandom_range(0, b - 1)));
  endfunction

  // mostly well-formed numbers with random content, some noise and broken ones
  function automatic void build_string(input logic [5:0] rdx);
    logic [5:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 1))
      repeat ($urandom_range(1, 3)) chars.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: chars.push_back(CH_PLUS);
      1: chars.push_back(CH_MINUS);
      default: ;
    endcase
    b = rdx;
    if (rdx == RADIX_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          chars.push_back(CH_ZERO);
          chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          b = RADIX_HEX;
        end
        1: begin
          chars.push_back(CH_ZERO);
          b = RADIX_OCT;
        end
        default: b = RADIX_DEC;
      endcase
    end else if (rdx == RADIX_HEX && $urandom_range(0, 1)) begin
      chars.push_back(CH_ZERO);
      chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    if (!(b >= RADIX_MIN && b <= RADIX_MAX)) b = 6'($urandom_range(2, 36));
    add_number(b);
    // tail: junk after the number, or an early null
    case ($urandom_range(0, 5))
      0: begin
        chars.push_back(8'($urandom_range(33, 47)));
        repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        chars.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  task automatic random_phase(input logic [5:0] rdx);
    int goal;
    goal = sent + STRING_ITEMS;
    while (sent < goal) begin
      if ($urandom_range(0, 7) == 0) calm_in = !calm_in;
      build_string(rdx);
      send_chars();
      if ($urandom_range(0, 24) == 0) settle();
    end
  endtask

  // stimulus
  initial begin
    logic [5:0] plan[13];
    plan = '{RADIX_AUTO, RADIX_MIN, RADIX_MAX, RADIX_HEX, RADIX_OCT, RADIX_DEC,
             6'd1, 6'd63, 6'd37, RADIX_AUTO, 6'd7, 6'd0, 6'd0};
    plan[11] = 6'($urandom_range(2, 36));
    plan[12] = 6'($urandom_range(0, 63));
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.is_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings under the reset radix
    send_text(" \t-12");
    send_text("+");
    // early null: the trailing digit is swallowed
    add_text("9");
    chars.push_back(CH_NUL);
    add_text("5");
    send_chars();
    send_text("x");
    set_radix(RADIX_AUTO);
    send_text("0x1F");
    send_text("017");
    // prefix with no hex digit after it
    send_text("0xg");
    set_radix(RADIX_HEX);
    send_text("0XfF");
    set_radix(6'd1);
    send_text("5");
    set_radix(RADIX_MAX);
    send_text("zZ");

    set_radix(RADIX_DEC);
    random_phase(RADIX_DEC);
    foreach (plan[i]) begin
      set_radix(plan[i]);
      random_phase(plan[i]);
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[string_to_unsigned_parser_core] OK");
    end else begin
      $display("[string_to_unsigned_parser_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/stup_pkg.sv
src/stup_in_if.sv
src/stup_out_if.sv
src/stup_ctrl.sv
src/stup_dp.sv
src/string_to_unsigned_parser_core.sv
src/stup_checker.sv
test/stup_checker.sv
test/tb.sv
